>>> hdl/md4_hash_engine_defines.svh
// Assertion helpers for the MD4 engine.
`ifndef MD4_HASH_ENGINE_DEFINES_SVH
`define MD4_HASH_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define MD4_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define MD4_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/md4_pkg.sv
package md4_pkg;

   typedef struct packed {
      logic [31:0] message_word;
      logic [2:0]  byte_count;
      logic        final_item;
   } md4_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_of_digest;
   } md4_rsp_type;

   localparam logic [31:0] K_RND2 = 32'h5a827999;
   localparam logic [31:0] K_RND3 = 32'h6ed9eba1;
   localparam logic [31:0] IV_A   = 32'h67452301;
   localparam logic [31:0] IV_B   = 32'hefcdab89;
   localparam logic [31:0] IV_C   = 32'h98badcfe;
   localparam logic [31:0] IV_D   = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   localparam logic [1:0] RND_1 = 2'd0;
   localparam logic [1:0] RND_2 = 2'd1;
   localparam logic [1:0] RND_3 = 2'd2;

   // microprogram addresses
   localparam int unsigned UPC_W = 6;
   localparam logic [UPC_W-1:0] UA_IDLE   = 6'd0;
   localparam logic [UPC_W-1:0] UA_LOAD   = 6'd1;
   localparam logic [UPC_W-1:0] UA_ROUND0 = 6'd2;
   localparam logic [UPC_W-1:0] UA_ADD    = 6'd50;
   localparam logic [UPC_W-1:0] UA_PAD    = 6'd51;
   localparam logic [UPC_W-1:0] UA_EMIT   = 6'd52;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_LOAD,
      OP_ROUND,
      OP_ADD,
      OP_PAD,
      OP_EMIT
   } md4_op_type;

   typedef struct packed {
      md4_op_type       op;
      logic [1:0]       rnd;
      logic [4:0]       shamt;
      logic [3:0]       rd_idx;   // buffer word fetched this step, used next step
      logic [UPC_W-1:0] target;   // conditional jump target
   } md4_ucode_type;

   // message word order per round
   function automatic logic [3:0] md4_msg_idx(input logic [1:0] rnd, input logic [3:0] i);
      logic [3:0] idx;
      case (rnd)
         RND_1:   idx = i;
         RND_2:   idx = {i[1:0], i[3:2]};
         default: idx = {i[0], i[1], i[2], i[3]};
      endcase
      return idx;
   endfunction

   function automatic logic [4:0] md4_shift(input logic [1:0] rnd, input logic [1:0] j);
      logic [4:0] s;
      case ({rnd, j})
         {RND_1, 2'd0}: s = 5'd3;
         {RND_1, 2'd1}: s = 5'd7;
         {RND_1, 2'd2}: s = 5'd11;
         {RND_1, 2'd3}: s = 5'd19;
         {RND_2, 2'd0}: s = 5'd3;
         {RND_2, 2'd1}: s = 5'd5;
         {RND_2, 2'd2}: s = 5'd9;
         {RND_2, 2'd3}: s = 5'd13;
         {RND_3, 2'd0}: s = 5'd3;
         {RND_3, 2'd1}: s = 5'd9;
         {RND_3, 2'd2}: s = 5'd11;
         default:       s = 5'd15;
      endcase
      return s;
   endfunction

   // control store
   function automatic md4_ucode_type md4_ucode(input logic [UPC_W-1:0] addr);
      md4_ucode_type    uc;
      logic [UPC_W-1:0] s;
      logic [UPC_W-1:0] sn;
      uc = '{op: OP_IDLE, rnd: RND_1, shamt: 5'd0, rd_idx: 4'd0, target: UA_IDLE};
      s  = addr - UA_ROUND0;
      sn = s + 6'd1;
      if (addr == UA_IDLE) begin
         uc.op     = OP_IDLE;
         uc.target = UA_PAD;
      end else if (addr == UA_LOAD) begin
         uc.op     = OP_LOAD;
         uc.rd_idx = md4_msg_idx(RND_1, 4'd0);
      end else if (addr < UA_ADD) begin
         uc.op    = OP_ROUND;
         uc.rnd   = s[5:4];
         uc.shamt = md4_shift(s[5:4], s[1:0]);
         if (sn < 6'd48) begin
            uc.rd_idx = md4_msg_idx(sn[5:4], sn[3:0]);
         end
      end else if (addr == UA_ADD) begin
         uc.op     = OP_ADD;
         uc.target = UA_PAD;
      end else if (addr == UA_PAD) begin
         uc.op     = OP_PAD;
         uc.target = UA_LOAD;
      end else if (addr == UA_EMIT) begin
         uc.op = OP_EMIT;
      end
      return uc;
   endfunction

endpackage

>>> hdl/md4_hash_engine.sv
// channel   dir  handshake            payload
// req_      in   req_valid/req_ready  md4_req_type: message word, byte count, final
// rsp_      out  rsp_valid/rsp_ready  md4_rsp_type: digest word, index, last
//
// A word is taken in the idle step; every 16th word runs LOAD, 48 round steps and
// ADD before the next word is taken. The last word adds padding steps plus one or
// two compressions, then four digest words from a one-deep output register.
// Reset (synchronous, active high) restores the MD4 initial chaining words.
// req_ready is high only in the idle step; a stalled rsp_ready holds the digest.
module md4_hash_engine
   import md4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  md4_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output md4_rsp_type rsp_data
);

`include "md4_hash_engine_defines.svh"

   // sequencer
   logic [UPC_W-1:0] upc_ff, upc_in;
   md4_ucode_type    uc;

   // chaining and working words
   logic [31:0] cv_ff [4];
   logic [31:0] cv_in [4];
   logic [31:0] wa_ff, wb_ff, wc_ff, wd_ff;
   logic [31:0] wa_in, wb_in, wc_in, wd_in;

   // block buffer: one write port, one registered read port
   logic [31:0] buf_mem [16];
   logic [31:0] rd_word_ff;
   logic        buf_we;
   logic [31:0] buf_wdata;

   logic [3:0]  wib_ff, wib_in;          // words in current block
   logic [60:0] nbytes_ff, nbytes_in;    // message length in bytes
   logic        pad_ff, pad_in;          // padding still to push
   logic        need80_ff, need80_in;    // 0x80 word still owed
   logic        lenlo_ff, lenlo_in;      // low length word pushed
   logic        emit_ff, emit_in;        // digest ready after this compress
   logic [1:0]  oidx_ff, oidx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   md4_rsp_type rsp_data_ff, rsp_data_in;

   logic        req_fire;
   logic        rsp_load;
   logic [2:0]  cnt_sat;
   logic [31:0] kept;
   logic [31:0] f_val, k_val, t_sum, rot;
   logic [63:0] bit_len;

   assign uc        = md4_ucode(upc_ff);
   assign req_ready = (uc.op == OP_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign bit_len   = {nbytes_ff, 3'b000};

   // round function
   always_comb begin
      case (uc.rnd)
         RND_1: begin
            f_val = (wb_ff & wc_ff) | (~wb_ff & wd_ff);
            k_val = '0;
         end
         RND_2: begin
            f_val = (wb_ff & wc_ff) | (wb_ff & wd_ff) | (wc_ff & wd_ff);
            k_val = K_RND2;
         end
         default: begin
            f_val = wb_ff ^ wc_ff ^ wd_ff;
            k_val = K_RND3;
         end
      endcase
      t_sum = wa_ff + f_val + k_val + rd_word_ff;
      rot   = (t_sum << uc.shamt) | (t_sum >> (6'd32 - {1'b0, uc.shamt}));
   end

   // final-word byte trim
   always_comb begin
      cnt_sat = (req_data.byte_count > 3'd4) ? 3'd4 : req_data.byte_count;
      case (cnt_sat[1:0])
         2'd0:    kept = {24'h0, PAD_BYTE};
         2'd1:    kept = {16'h0, PAD_BYTE, req_data.message_word[7:0]};
         2'd2:    kept = {8'h0, PAD_BYTE, req_data.message_word[15:0]};
         default: kept = {PAD_BYTE, req_data.message_word[23:0]};
      endcase
   end

   always_comb begin
      upc_in       = upc_ff;
      cv_in        = cv_ff;
      wa_in        = wa_ff;
      wb_in        = wb_ff;
      wc_in        = wc_ff;
      wd_in        = wd_ff;
      wib_in       = wib_ff;
      nbytes_in    = nbytes_ff;
      pad_in       = pad_ff;
      need80_in    = need80_ff;
      lenlo_in     = lenlo_ff;
      emit_in      = emit_ff;
      oidx_in      = oidx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      buf_we       = 1'b0;
      buf_wdata    = req_data.message_word;

      unique case (uc.op)
         OP_IDLE: begin
            if (req_fire) begin
               buf_we = 1'b1;
               wib_in = wib_ff + 4'd1;
               if (!req_data.final_item) begin
                  nbytes_in = nbytes_ff + 61'd4;
               end else begin
                  nbytes_in = nbytes_ff + {58'd0, cnt_sat};
                  pad_in    = 1'b1;
                  if (cnt_sat == 3'd4) begin
                     need80_in = 1'b1;
                  end else begin
                     buf_wdata = kept;
                  end
               end
               if (wib_ff == 4'd15) begin
                  upc_in = UA_LOAD;
               end else if (req_data.final_item) begin
                  upc_in = uc.target;
               end
            end
         end
         OP_LOAD: begin
            wa_in  = cv_ff[0];
            wb_in  = cv_ff[1];
            wc_in  = cv_ff[2];
            wd_in  = cv_ff[3];
            upc_in = upc_ff + 6'd1;
         end
         OP_ROUND: begin
            wa_in  = wd_ff;
            wd_in  = wc_ff;
            wc_in  = wb_ff;
            wb_in  = rot;
            upc_in = upc_ff + 6'd1;
         end
         OP_ADD: begin
            cv_in[0] = cv_ff[0] + wa_ff;
            cv_in[1] = cv_ff[1] + wb_ff;
            cv_in[2] = cv_ff[2] + wc_ff;
            cv_in[3] = cv_ff[3] + wd_ff;
            if (emit_ff) begin
               upc_in = UA_EMIT;
            end else if (pad_ff) begin
               upc_in = uc.target;
            end else begin
               upc_in = UA_IDLE;
            end
         end
         OP_PAD: begin
            buf_we = 1'b1;
            wib_in = wib_ff + 4'd1;
            if (need80_ff) begin
               buf_wdata = {24'h0, PAD_BYTE};
               need80_in = 1'b0;
            end else if (wib_ff == 4'd14) begin
               buf_wdata = bit_len[31:0];
               lenlo_in  = 1'b1;
            end else if (lenlo_ff) begin
               buf_wdata = bit_len[63:32];
               pad_in    = 1'b0;
               emit_in   = 1'b1;
            end else begin
               buf_wdata = '0;
            end
            if (wib_ff == 4'd15) begin
               upc_in = uc.target;
            end
         end
         OP_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.digest_word    = cv_ff[oidx_ff];
               rsp_data_in.word_index     = oidx_ff;
               rsp_data_in.last_of_digest = (oidx_ff == 2'd3);
               oidx_in                    = oidx_ff + 2'd1;
               if (oidx_ff == 2'd3) begin
                  cv_in[0]  = IV_A;
                  cv_in[1]  = IV_B;
                  cv_in[2]  = IV_C;
                  cv_in[3]  = IV_D;
                  nbytes_in = '0;
                  lenlo_in  = 1'b0;
                  emit_in   = 1'b0;
                  upc_in    = UA_IDLE;
               end
            end
         end
         default: upc_in = UA_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UA_IDLE;
         cv_ff[0]     <= IV_A;
         cv_ff[1]     <= IV_B;
         cv_ff[2]     <= IV_C;
         cv_ff[3]     <= IV_D;
         wib_ff       <= '0;
         nbytes_ff    <= '0;
         pad_ff       <= 1'b0;
         need80_ff    <= 1'b0;
         lenlo_ff     <= 1'b0;
         emit_ff      <= 1'b0;
         oidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         cv_ff        <= cv_in;
         wib_ff       <= wib_in;
         nbytes_ff    <= nbytes_in;
         pad_ff       <= pad_in;
         need80_ff    <= need80_in;
         lenlo_ff     <= lenlo_in;
         emit_ff      <= emit_in;
         oidx_ff      <= oidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff       <= wa_in;
      wb_ff       <= wb_in;
      wc_ff       <= wc_in;
      wd_ff       <= wd_in;
      rsp_data_ff <= rsp_data_in;
   end

   // block buffer
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[wib_ff] <= buf_wdata;
      end
      rd_word_ff <= buf_mem[uc.rd_idx];
   end

   // a message always ends on a block boundary
   `MD4_ASSERT_NOW(a_end_on_boundary, (uc.op == OP_ADD) && emit_ff, wib_ff == 4'd0, "digest compress not block aligned")

   // after the last digest word is loaded the chain is back at the initial values
   `MD4_ASSERT_NEXT(a_chain_restart, (uc.op == OP_EMIT) && rsp_load && (oidx_ff == 2'd3), (cv_ff[0] == IV_A) && (cv_ff[3] == IV_D) && (upc_ff == UA_IDLE) && (nbytes_ff == '0), "chain not restarted after digest")

   // digest words follow one another without gaps
   `MD4_ASSERT_NEXT(a_digest_stream, rsp_valid && rsp_ready && !rsp_data.last_of_digest, rsp_valid && (rsp_data.word_index == $past(rsp_data.word_index) + 2'd1), "digest word missing or out of order")

endmodule

>>> tb/md4_hash_engine_tb.sv
module md4_hash_engine_tb;
   import md4_pkg::*;

   // ------------------------------------------------------------------
   // Run constants
   // ------------------------------------------------------------------
   localparam int unsigned CLK_HALF        = 10;
   localparam int unsigned RANDOM_WORDS    = 180;
   // Long output stall used to back the engine up into its input side.
   localparam int unsigned HOLD_CYCLES     = 400;
   // One or two compressions plus padding and the digest register.
   localparam int unsigned DRAIN_CYCLES    = 200;
   localparam int unsigned TIMEOUT_CYCLES  = 300000;

   // Per-step rotate amounts, 5 bits each, entry = round * 4 + (step mod 4).
   localparam logic [59:0] ROT_TABLE = {5'd15, 5'd11, 5'd9, 5'd3,
                                        5'd13, 5'd9, 5'd5, 5'd3,
                                        5'd19, 5'd11, 5'd7, 5'd3};
   // Buffer word fetched at each step, one nibble per step, one 64-bit row
   // per round (row 0 in the low bits).
   localparam logic [191:0] WORD_ORDER = {64'hF7B3D591E6A2C480,
                                          64'hFB73EA62D951C840,
                                          64'hFEDCBA9876543210};

   // ------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   md4_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   md4_rsp_type rsp_data;

   md4_hash_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shared run state
   // ------------------------------------------------------------------
   md4_rsp_type digest_words_due[$];   // predicted digest words, oldest first
   int unsigned mismatch_count;
   int unsigned words_sent;
   int unsigned messages_sent;
   int unsigned digest_words_checked;
   int unsigned long_holds_done;
   bit          tx_gaps_on;            // sender inserts random gaps
   bit          rx_stalls_on;          // receiver inserts random stalls
   bit          rsp_hold_request;      // ask the receiver for one long stall

   // ------------------------------------------------------------------
   // MD4 predictor: own copy of chaining words, block buffer and length
   // ------------------------------------------------------------------
   logic [31:0] chain_words [4];
   logic [31:0] block_words [16];
   int unsigned block_fill;
   logic [60:0] msg_byte_total;        // wraps like the hardware counter

   function automatic void model_clear();
      chain_words[0] = IV_A;
      chain_words[1] = IV_B;
      chain_words[2] = IV_C;
      chain_words[3] = IV_D;
      block_fill     = 0;
      msg_byte_total = '0;
   endfunction

   // Three 16-step rounds over the full buffer, folded into the chain.
   function automatic void md4_compress_block();
      logic [31:0] a, b, c, d, f, k, t;
      logic [3:0]  w_sel;
      logic [4:0]  amt;
      int          r, i;
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      for (r = 0; r < 3; r++) begin
         for (i = 0; i < 16; i++) begin
            case (r)
               0: begin
                  f = (b & c) | (~b & d);
                  k = '0;
               end
               1: begin
                  f = (b & c) | (b & d) | (c & d);
                  k = K_RND2;
               end
               default: begin
                  f = b ^ c ^ d;
                  k = K_RND3;
               end
            endcase
            w_sel = WORD_ORDER[64*r + 4*i +: 4];
            amt   = ROT_TABLE[5*(4*r + i%4) +: 5];
            t     = a + f + k + block_words[w_sel];
            a     = d;
            d     = c;
            c     = b;
            b     = (t << amt) | (t >> (32 - amt));
         end
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
   endfunction

   function automatic void md4_push_block_word(input logic [31:0] w);
      block_words[block_fill[3:0]] = w;
      block_fill++;
      if (block_fill == 16) begin
         md4_compress_block();
         block_fill = 0;
      end
   endfunction

   // Absorb one accepted word; on the final word pad, finish and queue the
   // four digest words, then restart from the initial chain.
   function automatic void md4_absorb_word(input md4_req_type item);
      logic [2:0]  nbytes;
      logic [31:0] pad_word;
      logic [31:0] keep;
      logic [63:0] bit_len;
      md4_rsp_type dw;
      int          j;
      nbytes   = (item.byte_count > 3'd4) ? 3'd4 : item.byte_count;
      pad_word = {24'h0, PAD_BYTE};
      if (!item.final_item) begin
         // byte count ignored mid-message: all four bytes are taken
         md4_push_block_word(item.message_word);
         msg_byte_total += 61'd4;
      end else begin
         msg_byte_total += nbytes;
         if (nbytes == 3'd4) begin
            md4_push_block_word(item.message_word);
            md4_push_block_word(pad_word);
         end else begin
            keep = (32'h1 << (8 * nbytes)) - 32'h1;
            md4_push_block_word((item.message_word & keep) | (pad_word << (8 * nbytes)));
         end
         while (block_fill != 14)
            md4_push_block_word('0);
         bit_len = {msg_byte_total, 3'b000};
         md4_push_block_word(bit_len[31:0]);
         md4_push_block_word(bit_len[63:32]);
         for (j = 0; j < 4; j++) begin
            dw.digest_word    = chain_words[j[1:0]];
            dw.word_index     = j[1:0];
            dw.last_of_digest = (j == 3);
            digest_words_due.push_back(dw);
         end
         model_clear();
      end
   endfunction

   // ------------------------------------------------------------------
   // Mismatch reporting
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Sender side: one word per call, gap drawn per word, driven on negedge
   // ------------------------------------------------------------------
   task automatic send_message_word(input logic [31:0] data, input logic [2:0] nbytes,
                                    input logic is_final);
      md4_req_type item;
      int unsigned gap;
      item.message_word = data;
      item.byte_count   = nbytes;
      item.final_item   = is_final;
      gap = tx_gaps_on ? $urandom_range(0, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      md4_absorb_word(item);
      words_sent++;
      if (is_final)
         messages_sent++;
   endtask

   // Drop valid after the last word of a burst so nothing is re-offered.
   task automatic end_burst();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_message_word();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Body words carry random (ignored) byte counts, including 5..7.
   task automatic send_message(input int unsigned body_words, input logic [2:0] tail_bytes,
                               input logic [31:0] tail_word);
      int unsigned n;
      for (n = 0; n < body_words; n++)
         send_message_word(rand_message_word(), 3'($urandom_range(0, 7)), 1'b0);
      send_message_word(tail_word, tail_bytes, 1'b1);
   endtask

   task automatic wait_digests_drained();
      while (digest_words_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Receiver side: random stalls per word, plus the long hold on request.
   // ------------------------------------------------------------------
   initial begin : digest_receiver
      int unsigned stall;
      int unsigned held;
      rsp_ready = 1'b0;
      forever begin
         stall = rx_stalls_on ? $urandom_range(0, 12) : 0;
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            @(negedge clock);
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(negedge clock);
            long_holds_done++;
         end else if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         // wait for a handshake, or for a hold request to come in
         do @(posedge clock); while (!rsp_valid && !rsp_hold_request);
      end
   end

   // ------------------------------------------------------------------
   // Digest checker: every accepted word against the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin : digest_check
      md4_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_words_due.size() == 0) begin
            report_mismatch($sformatf("unexpected digest word %h idx %0d last %0b",
                                      rsp_data.digest_word, rsp_data.word_index,
                                      rsp_data.last_of_digest));
         end else begin
            want = digest_words_due.pop_front();
            digest_words_checked++;
            if (rsp_data.digest_word !== want.digest_word)
               report_mismatch($sformatf("digest_word got %h want %h (idx %0d)",
                                         rsp_data.digest_word, want.digest_word,
                                         want.word_index));
            if (rsp_data.word_index !== want.word_index)
               report_mismatch($sformatf("word_index got %0d want %0d",
                                         rsp_data.word_index, want.word_index));
            if (rsp_data.last_of_digest !== want.last_of_digest)
               report_mismatch($sformatf("last_of_digest got %0b want %0b (idx %0d)",
                                         rsp_data.last_of_digest, want.last_of_digest,
                                         want.word_index));
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Single-word messages: empty, one to four tail bytes, and tail counts
   // above four, which saturate. High bytes past the count must be dropped.
   task automatic test_short_tails();
      send_message(0, 3'd0, 32'hFFFF_FFFF);
      send_message(0, 3'd1, 32'hFFFF_FF61);
      send_message(0, 3'd2, 32'h0000_0000);
      send_message(0, 3'd3, 32'hFFFF_FFFF);
      send_message(0, 3'd4, 32'hFFFF_FFFF);
      send_message(0, 3'd5, 32'h0000_0000);
      send_message(0, 3'd6, $urandom);
      send_message(0, 3'd7, 32'hA5A5_5A5A);
      end_burst();
      wait_digests_drained();
   endtask

   // 0x80 lands in the last buffer word, so the length needs a second block.
   task automatic test_padding_boundaries();
      send_message(14, 3'd4, 32'hFFFF_FFFF);
      end_burst();
      wait_digests_drained();
   endtask

   // Receiver holds off for a long stretch while the sender keeps going:
   // the digest register fills, the engine stalls and req_ready drops.
   task automatic test_output_backpressure();
      tx_gaps_on       = 1'b0;
      rsp_hold_request = 1'b1;
      send_message(1, 3'd2, $urandom);
      send_message(1, 3'd4, $urandom);
      send_message(0, 3'd1, $urandom);
      end_burst();
      wait_digests_drained();
      tx_gaps_on = 1'b1;
   endtask

   // Random messages, lengths weighted around block boundaries and
   // multi-block lengths; idling switched on and off per message.
   task automatic test_random_messages();
      int unsigned start_words;
      int unsigned body;
      int unsigned pick;
      logic [2:0]  tail;
      start_words = words_sent;
      while (words_sent - start_words < RANDOM_WORDS) begin
         tx_gaps_on   = ($urandom_range(0, 3) != 0);
         rx_stalls_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 4)
            body = $urandom_range(0, 11);
         else if (pick < 7)
            body = $urandom_range(12, 17);
         else if (pick < 9)
            body = $urandom_range(28, 33);
         else
            body = $urandom_range(44, 49);
         pick = $urandom_range(0, 9);
         tail = (pick < 8) ? 3'(pick % 5) : 3'($urandom_range(5, 7));
         send_message(body, tail, rand_message_word());
      end
      end_burst();
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
      wait_digests_drained();
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_data             = '0;
      tx_gaps_on           = 1'b1;
      rx_stalls_on         = 1'b1;
      rsp_hold_request     = 1'b0;
      mismatch_count       = 0;
      words_sent           = 0;
      messages_sent        = 0;
      digest_words_checked = 0;
      long_holds_done      = 0;
      model_clear();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_short_tails();
      test_padding_boundaries();
      test_output_backpressure();
      test_random_messages();

      $display("Sent %0d message words in %0d messages; %0d digest words checked.",
               words_sent, messages_sent, digest_words_checked);
      $display("Covered empty/partial/saturated tails, two-block padding and %0d long stall(s).",
               long_holds_done);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #(2 * CLK_HALF * TIMEOUT_CYCLES);
      $display("Timeout: %0d digest words still expected.", digest_words_due.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
